### design/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// Used by the allocator top level; has no dependencies of its own.
package ffha_pkg;

    localparam int AW = 24;   // address, size and limit width
    localparam int XW = 26;   // header plus request plus alignment slack
    localparam int SW = 3;    // status width

    typedef logic [AW-1:0] t_addr;

    // One block table entry as it is held in the table memory.
    typedef struct packed {
        t_addr start;
        t_addr size;
        logic  is_free;
    } t_entry;

    localparam int EW = $bits(t_entry);

    localparam logic [SW-1:0] ST_REUSED       = 3'd0;
    localparam logic [SW-1:0] ST_GROWN        = 3'd1;
    localparam logic [SW-1:0] ST_OUT_OF_HEAP  = 3'd2;
    localparam logic [SW-1:0] ST_TABLE_FULL   = 3'd3;
    localparam logic [SW-1:0] ST_FREED_KEPT   = 3'd4;
    localparam logic [SW-1:0] ST_FREED_REL    = 3'd5;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

### design/ffha_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/first_fit_heap_allocator_unit.sv
// First-fit heap allocator: top level with the request sequencer.
// Depends on ffha_pkg and ffha_ram (block table memory).
//
// Usage: requests arrive as items on the slave stream (tuser = op, 0 allocate,
// 1 free; tdata = request_bytes, then payload_address). Each request gives one
// result item on the master stream (tuser = status, then bad_free; tdata =
// result_address). The heap limit is written through the cfg channel, which
// is always ready; write it only while no request is in flight.
// Timing: one request is worked at a time. The walk reads one table entry per
// cycle from the block table memory and stops at the first match. An allocate
// first passes through S_QUOT and S_TOTAL, which round header plus request up
// to the alignment with a reciprocal multiply. The input is ready again in the
// cycle after the result is loaded.
// Reset empties the table and the heap and sets the limit to all ones; the
// table memory itself is not cleared. A new request may be accepted while a
// result waits in the output register; if the receiver stalls, the following
// request waits at its final step until the output register is free.
module first_fit_heap_allocator_unit #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24,
    parameter int ALIGN_BYTES  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write: heap_limit.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data,
    // Request stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // [23:0] request_bytes, [47:24] payload_address
    input  logic        i_s_tuser,   // [0] op
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [23:0] result_address
    output logic [3:0]  o_m_tuser    // [2:0] status, [3] bad_free
);

    localparam int AW = ffha_pkg::AW;
    localparam int XW = ffha_pkg::XW;
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int LS = $clog2(ALIGN_BYTES);
    localparam int SH = XW + LS;
    localparam int MW = XW + 1;

    // Scaled reciprocal of the alignment; the quotient it gives is exact for
    // every dividend below 2**XW.
    localparam logic [MW-1:0] RECIP   = MW'(((64'd1 << SH) + 64'(ALIGN_BYTES) - 64'd1)
                                            / 64'(ALIGN_BYTES));
    localparam logic [XW-1:0] ALIGN_X = XW'(ALIGN_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUOT,
        S_TOTAL,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic                       r_op;
    ffha_pkg::t_addr            r_req;
    ffha_pkg::t_addr            r_addr;
    ffha_pkg::t_addr            r_limit;
    ffha_pkg::t_addr            r_top;
    logic [CW-1:0]              r_count;
    logic [XW-1:0]              r_x;
    logic [XW-1:0]              r_total;
    logic [XW-1:0]              r_q;
    logic [CW-1:0]              r_rd_idx;
    logic                       r_chk_valid;
    logic [IW-1:0]              r_chk_idx;
    logic                       r_hit;
    logic [IW-1:0]              r_hit_idx;
    ffha_pkg::t_entry           r_hit_entry;
    logic                       r_out_valid;
    logic [ffha_pkg::SW-1:0]    r_out_status;
    ffha_pkg::t_addr            r_out_addr;
    logic                       r_out_bad;

    logic [ffha_pkg::EW-1:0]    w_rdata_raw;
    ffha_pkg::t_entry           w_rd;
    logic                       w_we;
    logic [IW-1:0]              w_waddr;
    ffha_pkg::t_entry           w_wdata;
    logic                       w_match;
    logic                       w_miss;
    logic [XW+MW-1:0]           w_prod;
    logic [XW:0]                w_sum;
    logic                       w_out_free;
    logic                       w_last;

    ffha_ram #(
        .WIDTH (ffha_pkg::EW),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (w_rdata_raw)
    );

    assign w_rd = ffha_pkg::t_entry'(w_rdata_raw);

    // Match test on the entry that arrived from the table this cycle.
    always_comb begin
        if (r_op == ffha_pkg::OP_ALLOC) begin
            w_match = w_rd.is_free && (w_rd.size >= r_req);
        end else begin
            w_match = ((AW+1)'(w_rd.start) + (AW+1)'(HEADER_BYTES)) == (AW+1)'(r_addr);
        end
    end

    assign w_miss = !(r_chk_valid && w_match) && (r_rd_idx >= r_count);

    // r_x already carries the alignment minus one, so the quotient rounds up.
    assign w_prod     = (XW+MW)'(r_x) * (XW+MW)'(RECIP);

    assign w_sum      = (XW+1)'(r_top) + (XW+1)'(r_total);
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_last     = (CW'(r_hit_idx) + CW'(1)) == r_count;

    // Table write-back happens in the final step, when the result is loaded.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_hit_idx;
        w_wdata = r_hit_entry;
        if (r_state == S_DONE && w_out_free) begin
            if (r_hit) begin
                w_we            = 1'b1;
                w_wdata.is_free = (r_op == ffha_pkg::OP_FREE);
            end else if (r_op == ffha_pkg::OP_ALLOC
                         && !(w_sum > (XW+1)'(r_limit))
                         && r_count < CW'(MAX_BLOCKS)) begin
                w_we            = 1'b1;
                w_waddr         = r_count[IW-1:0];
                w_wdata.start   = r_top;
                w_wdata.size    = r_req;
                w_wdata.is_free = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= '1;
            r_top       <= '0;
            r_count     <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_op        <= i_s_tuser;
                        r_req       <= i_s_tdata[23:0];
                        r_addr      <= i_s_tdata[47:24];
                        r_x         <= XW'(i_s_tdata[23:0])
                                       + XW'(HEADER_BYTES + ALIGN_BYTES - 1);
                        r_rd_idx    <= '0;
                        r_chk_valid <= 1'b0;
                        r_state     <= (i_s_tuser == ffha_pkg::OP_ALLOC) ? S_QUOT : S_SCAN;
                    end
                end
                S_QUOT: begin
                    r_q     <= XW'(w_prod >> SH);
                    r_state <= S_TOTAL;
                end
                S_TOTAL: begin
                    r_total <= r_q * ALIGN_X;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_chk_valid && w_match) begin
                        r_hit       <= 1'b1;
                        r_hit_idx   <= r_chk_idx;
                        r_hit_entry <= w_rd;
                        r_chk_valid <= 1'b0;
                        r_state     <= S_DONE;
                    end else if (w_miss) begin
                        r_hit       <= 1'b0;
                        r_chk_valid <= 1'b0;
                        r_state     <= S_DONE;
                    end else begin
                        r_chk_valid <= 1'b1;
                        r_chk_idx   <= r_rd_idx[IW-1:0];
                        r_rd_idx    <= r_rd_idx + CW'(1);
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        if (r_op == ffha_pkg::OP_ALLOC) begin
                            r_out_bad <= 1'b0;
                            if (r_hit) begin
                                r_out_status <= ffha_pkg::ST_REUSED;
                                r_out_addr   <= AW'(r_hit_entry.start + AW'(HEADER_BYTES));
                            end else if (w_sum > (XW+1)'(r_limit)) begin
                                r_out_status <= ffha_pkg::ST_OUT_OF_HEAP;
                                r_out_addr   <= '0;
                            end else if (r_count >= CW'(MAX_BLOCKS)) begin
                                r_out_status <= ffha_pkg::ST_TABLE_FULL;
                                r_out_addr   <= '0;
                            end else begin
                                r_out_status <= ffha_pkg::ST_GROWN;
                                r_out_addr   <= AW'(r_top + AW'(HEADER_BYTES));
                                r_count      <= r_count + CW'(1);
                                r_top        <= w_sum[AW-1:0];
                            end
                        end else begin
                            r_out_addr <= '0;
                            r_out_bad  <= !r_hit;
                            if (!r_hit) begin
                                r_out_status <= ffha_pkg::ST_FREED_KEPT;
                            end else if (w_last) begin
                                // Freeing the topmost block hands its space back.
                                r_out_status <= ffha_pkg::ST_FREED_REL;
                                r_top        <= r_hit_entry.start;
                                r_count      <= r_count - CW'(1);
                            end else begin
                                r_out_status <= ffha_pkg::ST_FREED_KEPT;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_addr;
    assign o_m_tuser   = {r_out_bad, r_out_status};

endmodule
